// File: hw/rtl/qkhc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the quantized key hash cache.
// No dependencies; used by every module under hw/rtl.
package qkhc_pkg;

	localparam int TABLE_SLOTS_DEF = 2048;
	localparam int MAX_PROBES_DEF  = 32;

	localparam int COORD_W  = 32;
	localparam int VALUE_W  = 32;
	localparam int KEY_W    = 64;
	localparam int LIMIT_W  = 6;
	localparam int OCC_W    = 12;

	localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;
	localparam int HASH_SHIFT = 40;
	localparam int HOME_W     = 64 - HASH_SHIFT;
	localparam int HOME_LSB   = HASH_SHIFT - 32;

	localparam logic [LIMIT_W-1:0] LOOKUP_LIMIT_RST = 6'd8;
	localparam logic [LIMIT_W-1:0] STORE_LIMIT_RST  = 6'd32;

	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOKUP_LIMIT = 1'b0,
		REG_STORE_LIMIT  = 1'b1
	} cfg_reg_t;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_STORE  = 1'b1;

	localparam int Q_DEPTH = 2;
	localparam int QCNT_W  = 2;
	localparam int QPTR_W  = 1;

	// one hashed item waiting for the probe engine
	typedef struct packed {
		logic               action;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [HOME_W-1:0]  home;
	} work_t;

	typedef struct packed {
		logic               used;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} slot_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} q_status_t;

	typedef struct packed {
		logic               done;
		logic               hit;
		logic [VALUE_W-1:0] found_value;
		logic               dropped;
		logic [OCC_W-1:0]   occupied_slots;
	} result_t;

endpackage

// File: hw/rtl/qkhc_front.sv
`timescale 1ns / 1ps
// Front end: accepts a word, quantizes the coordinates, builds the key and
// computes the home slot from a registered multiply. Depends on qkhc_pkg.
module qkhc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                action,
	input  logic signed [qkhc_pkg::COORD_W-1:0] coord_x,
	input  logic signed [qkhc_pkg::COORD_W-1:0] coord_z,
	input  logic signed [qkhc_pkg::VALUE_W-1:0] new_value,
	input  logic                                clearing,
	input  qkhc_pkg::q_status_t                 q_st,
	output logic                                busy,
	output logic                                push,
	output qkhc_pkg::work_t                     push_data
);

	logic                          accept;
	logic [31:0]                   qx;
	logic [31:0]                   qz;
	logic [31:0]                   hash_hi;

	logic                          valid_s1;
	logic                          action_s1;
	logic [qkhc_pkg::KEY_W-1:0]    key_s1;
	logic [qkhc_pkg::VALUE_W-1:0]  value_s1;
	logic [63:0]                   p0_s1;
	logic [31:0]                   p1_s1;
	logic [31:0]                   p2_s1;

	// leave room in the queue for the word already in the hash stage
	assign busy = clearing
		|| (q_st.count == qkhc_pkg::QCNT_W'(qkhc_pkg::Q_DEPTH))
		|| (valid_s1 && q_st.count == qkhc_pkg::QCNT_W'(qkhc_pkg::Q_DEPTH - 1));
	assign accept = start && !busy;

	assign qx = {coord_x[31:2], 2'b00};
	assign qz = {coord_z[31:2], 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// low 64 bits of key * HASH_MUL from three 32x32 partial products
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			key_s1    <= {qz, qx};
			value_s1  <= new_value;
			p0_s1     <= {32'd0, qx} * {32'd0, qkhc_pkg::HASH_MUL[31:0]};
			p1_s1     <= qx * qkhc_pkg::HASH_MUL[63:32];
			p2_s1     <= qz * qkhc_pkg::HASH_MUL[31:0];
		end
	end

	assign hash_hi = p0_s1[63:32] + p1_s1 + p2_s1;

	assign push             = valid_s1;
	assign push_data.action = action_s1;
	assign push_data.key    = key_s1;
	assign push_data.value  = value_s1;
	assign push_data.home   = hash_hi[31:qkhc_pkg::HOME_LSB];

endmodule

// File: hw/rtl/qkhc_queue.sv
`timescale 1ns / 1ps
// Short FIFO of hashed words between the front end and the probe engine.
// Depends on qkhc_pkg.
module qkhc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qkhc_pkg::work_t     push_data,
	input  logic                pop,
	output qkhc_pkg::work_t     head,
	output qkhc_pkg::q_status_t q_st
);

	qkhc_pkg::work_t             q_mem [qkhc_pkg::Q_DEPTH];
	logic [qkhc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [qkhc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [qkhc_pkg::QCNT_W-1:0] cnt_q;

	assign head       = q_mem[rd_ptr_q];
	assign q_st.count = cnt_q;
	assign q_st.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == qkhc_pkg::QPTR_W'(qkhc_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == qkhc_pkg::QPTR_W'(qkhc_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != qkhc_pkg::QCNT_W'(qkhc_pkg::Q_DEPTH) || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue pop while empty");

endmodule

// File: hw/rtl/qkhc_back.sv
`timescale 1ns / 1ps
// Probe engine: clears the slot table after reset, then runs linear probes
// for lookups and stores and registers the result. Depends on qkhc_pkg.
module qkhc_back #(
	parameter int TABLE_SLOTS = qkhc_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_PROBES  = qkhc_pkg::MAX_PROBES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qkhc_pkg::work_t               head,
	input  qkhc_pkg::q_status_t           q_st,
	input  logic [qkhc_pkg::LIMIT_W-1:0]  lookup_limit,
	input  logic [qkhc_pkg::LIMIT_W-1:0]  store_limit,
	output logic                          pop,
	output logic                          clearing,
	output qkhc_pkg::result_t             res
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int LIM_W = $clog2(MAX_PROBES + 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE
	} state_t;

	state_t                          state_q;
	logic [IDX_W-1:0]                clr_idx_q;
	qkhc_pkg::work_t                 cur_q;
	logic [LIM_W-1:0]                lim_q;
	logic [LIM_W-1:0]                probe_q;
	logic [qkhc_pkg::OCC_W-1:0]      count_q;
	qkhc_pkg::result_t               res_q;
	qkhc_pkg::result_t               res_d;

	qkhc_pkg::slot_t                 slot_mem [TABLE_SLOTS];
	qkhc_pkg::slot_t                 rd_q;

	logic [qkhc_pkg::LIMIT_W-1:0]    head_lim_raw;
	logic [LIM_W-1:0]                head_lim;
	logic [IDX_W-1:0]                slot;
	logic                            slot_free;
	logic                            slot_match;
	logic                            last;
	logic                            store_op;
	logic                            probe_end;
	logic                            mem_we;
	logic [IDX_W-1:0]                mem_wa;
	qkhc_pkg::slot_t                 mem_wd;
	logic [IDX_W-1:0]                mem_ra;

	assign pop      = (state_q == ST_IDLE) && !q_st.empty;
	assign clearing = (state_q == ST_CLEAR);
	assign res      = res_q;

	always_comb begin
		head_lim_raw = (head.action == qkhc_pkg::ACT_STORE) ? store_limit : lookup_limit;
		if (32'(head_lim_raw) > MAX_PROBES) begin
			head_lim = LIM_W'(MAX_PROBES);
		end else begin
			head_lim = LIM_W'(head_lim_raw);
		end
	end

	// rd_q holds the slot for probe_q while in ST_PROBE
	assign slot       = cur_q.home[IDX_W-1:0] + IDX_W'(probe_q);
	assign slot_free  = !rd_q.used;
	assign slot_match = rd_q.used && (rd_q.key == cur_q.key);
	assign last       = (probe_q + LIM_W'(1)) == lim_q;
	assign store_op   = (cur_q.action == qkhc_pkg::ACT_STORE);
	assign probe_end  = slot_free || slot_match || last;

	always_comb begin
		case (state_q)
			ST_IDLE:  mem_ra = head.home[IDX_W-1:0];
			ST_PROBE: mem_ra = slot + IDX_W'(1);
			default:  mem_ra = clr_idx_q;
		endcase
	end

	assign mem_we = clearing || ((state_q == ST_PROBE)
		&& (cur_q.action == qkhc_pkg::ACT_STORE) && (slot_free || slot_match));
	assign mem_wa = clearing ? clr_idx_q : slot;
	assign mem_wd = clearing ? '0 : {1'b1, cur_q.key, cur_q.value};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_wa] <= mem_wd;
		end
		rd_q <= slot_mem[mem_ra];
	end

	// result of the word that finishes this cycle, if any
	always_comb begin
		res_d      = res_q;
		res_d.done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (pop && head_lim == '0) begin
					// no slot examined: lookup misses, store drops
					res_d.done           = 1'b1;
					res_d.hit            = 1'b0;
					res_d.found_value    = '0;
					res_d.dropped        = head.action;
					res_d.occupied_slots = count_q;
				end
			end
			ST_PROBE: begin
				if (probe_end) begin
					res_d.done           = 1'b1;
					res_d.hit            = !store_op && slot_match;
					res_d.found_value    = res_d.hit ? rd_q.value : '0;
					res_d.dropped        = store_op && !slot_free && !slot_match;
					res_d.occupied_slots = (store_op && slot_free) ?
						count_q + 1'b1 : count_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			cur_q     <= '0;
			lim_q     <= '0;
			probe_q   <= '0;
			count_q   <= '0;
			res_q     <= '0;
		end else begin
			res_q <= res_d;
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IDX_W'(TABLE_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						cur_q   <= head;
						lim_q   <= head_lim;
						probe_q <= '0;
						if (head_lim != '0) begin
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (probe_end) begin
						if (store_op && slot_free) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						probe_q <= probe_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_quiet_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !res_q.done)
		else $error("result during table clear");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (probe_q < lim_q))
		else $error("probe index past limit");

	a_hit_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.done |-> !(res_q.hit && res_q.dropped))
		else $error("hit and dropped together");

endmodule

// File: hw/rtl/quantized_key_hash_cache.sv
`timescale 1ns / 1ps
// Quantized key hash cache: open addressing table with linear probing.
// A word passes the front-end register and the queue, then the probe engine examines
// k slots (0 at a zero limit, else 1 to limit) and registers the result.
// The engine takes one word at a time, reading one slot a cycle from the slot table;
// the front end and the queue take new words while it probes, until busy is raised.
// After reset every slot of the table is cleared with busy high;
// config writes are taken throughout. done pulses one cycle; no backpressure.
module quantized_key_hash_cache #(
	parameter int TABLE_SLOTS = qkhc_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_PROBES  = qkhc_pkg::MAX_PROBES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [qkhc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qkhc_pkg::LIMIT_W-1:0]         cfg_data,
	input  logic                                 start,
	input  logic                                 action,
	input  logic signed [qkhc_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [qkhc_pkg::COORD_W-1:0]  coord_z,
	input  logic signed [qkhc_pkg::VALUE_W-1:0]  new_value,
	output logic                                 busy,
	output logic                                 done,
	output logic                                 hit,
	output logic signed [qkhc_pkg::VALUE_W-1:0]  found_value,
	output logic                                 dropped,
	output logic [qkhc_pkg::OCC_W-1:0]           occupied_slots
);

	logic [qkhc_pkg::LIMIT_W-1:0] lookup_limit_q;
	logic [qkhc_pkg::LIMIT_W-1:0] store_limit_q;

	logic                         clearing;
	logic                         push;
	logic                         pop;
	qkhc_pkg::work_t              push_data;
	qkhc_pkg::work_t              head;
	qkhc_pkg::q_status_t          q_st;
	qkhc_pkg::result_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_limit_q <= qkhc_pkg::LOOKUP_LIMIT_RST;
			store_limit_q  <= qkhc_pkg::STORE_LIMIT_RST;
		end else if (cfg_we) begin
			case (qkhc_pkg::cfg_reg_t'(cfg_index))
				qkhc_pkg::REG_LOOKUP_LIMIT: lookup_limit_q <= cfg_data;
				qkhc_pkg::REG_STORE_LIMIT:  store_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	qkhc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.coord_x   (coord_x),
		.coord_z   (coord_z),
		.new_value (new_value),
		.clearing  (clearing),
		.q_st      (q_st),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	qkhc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_st      (q_st)
	);

	qkhc_back #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.MAX_PROBES  (MAX_PROBES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_st         (q_st),
		.lookup_limit (lookup_limit_q),
		.store_limit  (store_limit_q),
		.pop          (pop),
		.clearing     (clearing),
		.res          (res)
	);

	assign done           = res.done;
	assign hit            = res.hit;
	assign found_value    = res.found_value;
	assign dropped        = res.dropped;
	assign occupied_slots = res.occupied_slots;

endmodule

// File: dv/tb_quantized_key_hash_cache.sv
`timescale 1ns / 1ps
// Self-checking testbench for quantized_key_hash_cache: directed and random words
// are scored against an in-bench model of the linearly probed table.
// Depends on qkhc_pkg and the RTL top only.
module tb_quantized_key_hash_cache;
	import qkhc_pkg::*;

	localparam int SLOTS = 2048;
	localparam int PROBE_CAP = 32;
	localparam int CYCLE_LIMIT = 600000;
	localparam int CLUSTER_KEYS = 10;
	localparam int POOL_SIZE = 64;

	typedef struct {
		logic               hit;
		logic [VALUE_W-1:0] found_value;
		logic               dropped;
		logic [OCC_W-1:0]   occupied_slots;
	} cache_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [LIMIT_W-1:0]         cfg_data = '0;
	logic                       start = 1'b0;
	logic                       action = 1'b0;
	logic signed [COORD_W-1:0]  coord_x = '0;
	logic signed [COORD_W-1:0]  coord_z = '0;
	logic signed [VALUE_W-1:0]  new_value = '0;
	logic                       busy;
	logic                       done;
	logic                       hit;
	logic signed [VALUE_W-1:0]  found_value;
	logic                       dropped;
	logic [OCC_W-1:0]           occupied_slots;

	quantized_key_hash_cache uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// model of the table
	bit                 tbl_used [SLOTS];
	logic [KEY_W-1:0]   tbl_key  [SLOTS];
	logic [VALUE_W-1:0] tbl_val  [SLOTS];
	int unsigned        tbl_count;
	logic [LIMIT_W-1:0] lookup_limit = LOOKUP_LIMIT_RST;
	logic [LIMIT_W-1:0] store_limit = STORE_LIMIT_RST;

	cache_result_t pending_results[$];
	int mismatches, cycle_count;
	int n_words, n_stores, n_drops, n_lookups, n_hits;

	logic [31:0] pool_x [POOL_SIZE];
	logic [31:0] pool_z [POOL_SIZE];
	logic [31:0] cl_x[$];
	logic [31:0] cl_z[$];

	function automatic logic [KEY_W-1:0] quant_key(logic [31:0] x, logic [31:0] z);
		return {z[31:2], 2'b00, x[31:2], 2'b00};
	endfunction

	function automatic logic [10:0] home_slot(logic [KEY_W-1:0] key);
		logic [63:0] prod;
		prod = key * HASH_MUL;
		return prod[50:40];
	endfunction

	// walks the probe chain, updates the model and returns the expected word
	function automatic cache_result_t probe_table(logic act, logic [31:0] x,
			logic [31:0] z, logic [31:0] v);
		cache_result_t r;
		logic [KEY_W-1:0] key;
		logic [10:0] s;
		int lim, p;
		key = quant_key(x, z);
		r = '{default: '0};
		n_words++;
		if (act == ACT_LOOKUP) begin
			n_lookups++;
			lim = (lookup_limit > PROBE_CAP) ? PROBE_CAP : int'(lookup_limit);
			for (p = 0; p < lim; p++) begin
				s = home_slot(key) + 11'(p);
				if (!tbl_used[s])
					break;
				if (tbl_key[s] == key) begin
					r.hit = 1'b1;
					r.found_value = tbl_val[s];
					n_hits++;
					break;
				end
			end
		end else begin
			n_stores++;
			lim = (store_limit > PROBE_CAP) ? PROBE_CAP : int'(store_limit);
			r.dropped = 1'b1;
			for (p = 0; p < lim; p++) begin
				s = home_slot(key) + 11'(p);
				if (!tbl_used[s]) begin
					tbl_used[s] = 1'b1;
					tbl_key[s] = key;
					tbl_val[s] = v;
					tbl_count++;
					r.dropped = 1'b0;
					break;
				end
				if (tbl_key[s] == key) begin
					tbl_val[s] = v;
					r.dropped = 1'b0;
					break;
				end
			end
			if (r.dropped)
				n_drops++;
		end
		r.occupied_slots = OCC_W'(tbl_count);
		return r;
	endfunction

	// random coordinates whose home slot lies within span slots of target
	function automatic logic [63:0] coords_near(logic [10:0] target, int span);
		logic [31:0] x, z;
		logic [10:0] d;
		do begin
			x = $urandom;
			z = $urandom;
			d = home_slot(quant_key(x, z)) - target;
		end while (d >= span);
		return {z, x};
	endfunction

	function automatic void build_key_sets();
		logic [63:0] c;
		logic [10:0] target;
		int i, k;
		for (i = 0; i < POOL_SIZE; i++) begin
			pool_x[i] = $urandom;
			pool_z[i] = $urandom;
		end
		// one cluster straddles the top of the table so its chains wrap
		for (i = 0; i < 4; i++) begin
			target = (i == 0) ? 11'd2040 : 11'($urandom);
			for (k = 0; k < CLUSTER_KEYS; k++) begin
				c = coords_near(target, 3);
				cl_x.push_back(c[31:0]);
				cl_z.push_back(c[63:32]);
			end
		end
	endfunction

	task automatic send_word(logic act, logic [31:0] x, logic [31:0] z, logic [31:0] v);
		action <= act;
		coord_x <= x;
		coord_z <= z;
		new_value <= v;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(probe_table(act, x, z, v));
	endtask

	task automatic idle_gap();
		start <= 1'b0;
		repeat ($urandom_range(1, 15)) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_limits(logic [LIMIT_W-1:0] lk, logic [LIMIT_W-1:0] st);
		cfg_we <= 1'b1;
		cfg_index <= REG_LOOKUP_LIMIT;
		cfg_data <= lk;
		@(posedge clk);
		cfg_index <= REG_STORE_LIMIT;
		cfg_data <= st;
		@(posedge clk);
		cfg_we <= 1'b0;
		lookup_limit = lk;
		store_limit = st;
		@(posedge clk);
	endtask

	task automatic send_random_word();
		int pick, i;
		logic act;
		logic [31:0] x, z;
		pick = $urandom_range(0, 99);
		act = 1'($urandom_range(0, 1));
		if (pick < 55) begin
			i = $urandom_range(0, POOL_SIZE - 1);
			x = (pool_x[i] & 32'hFFFF_FFFC) | 32'($urandom_range(0, 3));
			z = (pool_z[i] & 32'hFFFF_FFFC) | 32'($urandom_range(0, 3));
		end else if (pick < 80) begin
			i = $urandom_range(0, cl_x.size() - 1);
			x = cl_x[i];
			z = cl_z[i];
		end else begin
			x = $urandom;
			z = $urandom;
		end
		send_word(act, x, z, $urandom);
	endtask

	// runs at the reset limits: extreme coordinates, quantization aliasing, overwrite
	task automatic test_directed_basics();
		send_word(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678);
		send_word(ACT_STORE,  32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
		send_word(ACT_LOOKUP, 32'h0000_0003, 32'h0000_0003, 32'h0000_0000);
		send_word(ACT_STORE,  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(ACT_LOOKUP, 32'h8000_0003, 32'h7FFF_FFFC, 32'hFFFF_FFFF);
		idle_gap();
		send_word(ACT_STORE,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		send_word(ACT_LOOKUP, 32'h7FFF_FFFC, 32'h8000_0003, 32'h0000_0000);
		send_word(ACT_STORE,  32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF);
		send_word(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(ACT_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
		send_word(ACT_LOOKUP, 32'hFFFF_FFFC, 32'hFFFF_FFFE, 32'h0000_0000);
		drain();
	endtask

	// keys sharing one home slot at the table's top, so chains wrap through slot 0
	task automatic test_probe_limits();
		logic [63:0] k [5];
		int i;
		for (i = 0; i < 5; i++)
			k[i] = coords_near(11'd2047, 1);
		set_limits(6'd1, 6'd1);
		send_word(ACT_STORE,  k[0][31:0], k[0][63:32], 32'hA5A5_0001);
		send_word(ACT_STORE,  k[1][31:0], k[1][63:32], 32'hA5A5_0002);
		send_word(ACT_STORE,  k[0][31:0], k[0][63:32], 32'hA5A5_0003);
		send_word(ACT_LOOKUP, k[1][31:0], k[1][63:32], 32'h0000_0000);
		drain();
		// zero limit: nothing probed at all
		set_limits(6'd0, 6'd0);
		send_word(ACT_LOOKUP, k[0][31:0], k[0][63:32], 32'h0000_0000);
		send_word(ACT_STORE,  k[0][31:0], k[0][63:32], 32'hDEAD_BEEF);
		drain();
		// above the cap: saturates
		set_limits(6'd63, 6'd63);
		send_word(ACT_STORE,  k[1][31:0], k[1][63:32], 32'h0000_0011);
		send_word(ACT_STORE,  k[2][31:0], k[2][63:32], 32'h0000_0022);
		send_word(ACT_STORE,  k[3][31:0], k[3][63:32], 32'h0000_0033);
		send_word(ACT_LOOKUP, k[3][31:0], k[3][63:32], 32'h0000_0000);
		drain();
		set_limits(6'd2, 6'd32);
		send_word(ACT_LOOKUP, k[3][31:0], k[3][63:32], 32'h0000_0000);
		send_word(ACT_LOOKUP, k[0][31:0], k[0][63:32], 32'h0000_0000);
		send_word(ACT_LOOKUP, k[4][31:0], k[4][63:32], 32'h0000_0000);
		drain();
	endtask

	task automatic test_random_phases();
		logic [LIMIT_W-1:0] lk [6];
		logic [LIMIT_W-1:0] st [6];
		int ph, n, i;
		bit quiet;
		lk = '{6'd63, 6'd2, 6'd32, 6'd1, 6'd33, 6'd8};
		st = '{6'd63, 6'd2, 6'd1, 6'd32, 6'd3, 6'd32};
		lk[5] = LIMIT_W'($urandom_range(1, 63));
		st[5] = LIMIT_W'($urandom_range(1, 63));
		for (ph = 0; ph < 6; ph++) begin
			set_limits(lk[ph], st[ph]);
			for (i = 0; i < 16; i++) begin
				n = $urandom_range(0, POOL_SIZE - 1);
				pool_x[n] = $urandom;
				pool_z[n] = $urandom;
			end
			quiet = 1'b0;
			for (n = 0; n < 240; n++) begin
				if (n % 60 == 0)
					quiet = ($urandom_range(0, 2) == 0);
				send_random_word();
				if (!quiet && $urandom_range(0, 3) == 0)
					idle_gap();
			end
			drain();
		end
	endtask

	// back-to-back words at the reset limits, no gaps
	task automatic test_back_to_back();
		int n;
		set_limits(LOOKUP_LIMIT_RST, STORE_LIMIT_RST);
		for (n = 0; n < 200; n++)
			send_random_word();
	endtask

	always @(posedge clk) begin
		cache_result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				$error("result word with no expectation pending");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, actual %0d", want.hit, hit);
					mismatches++;
				end
				if (found_value !== want.found_value) begin
					$error("found_value: expected %08h, actual %08h",
						want.found_value, found_value);
					mismatches++;
				end
				if (dropped !== want.dropped) begin
					$error("dropped: expected %0d, actual %0d", want.dropped, dropped);
					mismatches++;
				end
				if (occupied_slots !== want.occupied_slots) begin
					$error("occupied_slots: expected %0d, actual %0d",
						want.occupied_slots, occupied_slots);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		build_key_sets();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_basics();
		test_probe_limits();
		test_random_phases();
		test_back_to_back();
		drain();
		$display("%0d words: %0d lookups (%0d hits), %0d stores (%0d dropped)",
			n_words, n_lookups, n_hits, n_stores, n_drops);
		$display("probe limits 0..63 on both registers, %0d slots in use at the end",
			tbl_count);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/qkhc_pkg.sv
hw/rtl/qkhc_front.sv
hw/rtl/qkhc_queue.sv
hw/rtl/qkhc_back.sv
hw/rtl/quantized_key_hash_cache.sv
dv/tb_quantized_key_hash_cache.sv
